### design/cau_pkg.sv
// ============================================================================
// cau_pkg
// Shared widths, codes and pipeline word types of the complex arithmetic unit.
// ============================================================================
package cau_pkg;

   localparam int IN_W          = 16;          // operand part, signed Q8.8
   localparam int RES_W         = 24;          // result part, signed
   localparam int PROD_W        = 2 * IN_W;    // one 16x16 product
   localparam int SUM_W         = PROD_W + 1;  // sum of two products
   localparam int MAG_W         = PROD_W;      // |sum| never exceeds 2^31
   localparam int DEN_W         = PROD_W;      // b_re^2 + b_im^2 <= 2^31
   localparam int REM_W         = DEN_W;       // partial remainder < den
   localparam int FRAC_BITS_DEF = 8;
   localparam int FRAC_BITS_MAX = 12;

   localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
   localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } cau_op_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DIV_ZERO = 2'd1,
      ST_SAT      = 2'd2
   } cau_status_type;

   // One result part inside the divider: remainder, numerator bits that are
   // shifted in from the top and replaced by quotient bits from the bottom.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [RES_W-1:0] bits;
      logic             neg;
      logic             ovf;
   } cau_part_type;

   typedef struct packed {
      cau_part_type     re;
      cau_part_type     im;
      logic [DEN_W-1:0] den;
      logic             dz;
   } cau_div_type;

endpackage

### design/cau_div_step.sv
// ============================================================================
// cau_div_step
// One restoring divide stage: one quotient bit per part, registered.
// ============================================================================
module cau_div_step
   import cau_pkg::*;
(
   input  logic        clock,
   input  logic        load,
   input  cau_div_type prev_word,
   output cau_div_type next_word
);

   cau_div_type step_in;
   cau_div_type step_ff;

   function automatic cau_part_type step_part(cau_part_type p, logic [DEN_W-1:0] den);
      logic [REM_W:0] trial;
      logic           qbit;
      cau_part_type   r;
      trial = {p.rem, p.bits[RES_W-1]};
      qbit  = (trial >= (REM_W+1)'(den));
      r     = p;
      if (qbit) begin
         r.rem = REM_W'(trial - (REM_W+1)'(den));
      end else begin
         r.rem = trial[REM_W-1:0];
      end
      r.bits = {p.bits[RES_W-2:0], qbit};
      return r;
   endfunction

   always_comb begin
      step_in    = prev_word;
      step_in.re = step_part(prev_word.re, prev_word.den);
      step_in.im = step_part(prev_word.im, prev_word.den);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         step_ff <= step_in;
      end
   end

   assign next_word = step_ff;

endmodule

### design/complex_arithmetic_unit_core.sv
// ============================================================================
// complex_arithmetic_unit_core
// Complex add, subtract, multiply and divide on signed fixed-point operands.
//
// Each input word carries an opcode and two complex operands a and b with
// 16-bit signed parts (FRAC_BITS fraction bits); each output word carries
// one complex result with 24-bit signed parts and a status code. Add and
// subtract work part by part. Multiply gives a*b scaled down by FRAC_BITS,
// truncated toward zero. Divide gives a*conj(b) / |b|^2 with FRAC_BITS
// fraction bits, truncated toward zero. A part outside the 24-bit range is
// clamped to the nearest bound and status reads saturated; b equal to zero
// on divide returns zero with status divide-by-zero. The unit takes one
// word per clock unless input is refused, and returns results in order
// through 29 register stages: one stage of six 16x16 multipliers, one of
// product sums, one of magnitudes, one of scaling and overflow check, 24
// restoring divide stages (one quotient bit each) and the output register.
// Every opcode flows through the divider; non-divide words use a divisor
// of one. Stages with no valid word fill in while the output is stalled,
// so input is refused only when all 29 stages hold words.
// ============================================================================
module complex_arithmetic_unit_core
   import cau_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_opcode,
   input  logic signed [IN_W-1:0]  req_a_re,
   input  logic signed [IN_W-1:0]  req_a_im,
   input  logic signed [IN_W-1:0]  req_b_re,
   input  logic signed [IN_W-1:0]  req_b_im,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [RES_W-1:0] rsp_res_re,
   output logic signed [RES_W-1:0] rsp_res_im,
   output logic [1:0]              rsp_status
);

   // Stage map: 0 products, 1 sums, 2 magnitudes, 3 scale/overflow,
   // 4..4+RES_W-1 divide steps, last one the output register.
   localparam int NUM_DIV  = RES_W;
   localparam int DIV_STG0 = 4;
   localparam int NSTG     = DIV_STG0 + NUM_DIV + 1;
   localparam int OUT_STG  = NSTG - 1;
   localparam int AS_W     = IN_W + 1;
   localparam int MW       = MAG_W + FRAC_BITS;

   typedef struct packed {
      logic [RES_W-1:0] val;
      logic             clamp;
   } cau_res_type;

   // ---------------------------------------------------------------------
   // Flow control: a stage loads when it is empty or some later stage is
   // empty or the output is taken, so bubbles collapse under a stall.
   // ---------------------------------------------------------------------
   logic [NSTG-1:0] valid_ff;
   logic [NSTG-1:0] valid_in;
   logic [NSTG-1:0] ready;

   for (genvar i = 0; i < NSTG; i++) begin : g_ready
      assign ready[i] = !rsp_stall || !(&valid_ff[NSTG-1:i]);
   end

   assign valid_in  = {valid_ff[NSTG-2:0], req_valid};
   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[OUT_STG];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (ready[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 0: all products plus the add/sub result
   // ---------------------------------------------------------------------
   cau_op_type               s1_op_in;
   logic signed [AS_W-1:0]   s1_as_re_in, s1_as_im_in;
   cau_op_type               s1_op_ff;
   logic signed [PROD_W-1:0] s1_p_rr_ff, s1_p_ii_ff, s1_p_ir_ff, s1_p_ri_ff;
   logic [PROD_W-1:0]        s1_sq_r_ff, s1_sq_i_ff;
   logic signed [AS_W-1:0]   s1_as_re_ff, s1_as_im_ff;

   always_comb begin
      s1_op_in = cau_op_type'(req_opcode);
      if (s1_op_in == OP_SUB) begin
         s1_as_re_in = AS_W'(req_a_re) - AS_W'(req_b_re);
         s1_as_im_in = AS_W'(req_a_im) - AS_W'(req_b_im);
      end else begin
         s1_as_re_in = AS_W'(req_a_re) + AS_W'(req_b_re);
         s1_as_im_in = AS_W'(req_a_im) + AS_W'(req_b_im);
      end
   end

   always_ff @(posedge clock) begin
      if (ready[0]) begin
         s1_op_ff    <= s1_op_in;
         s1_p_rr_ff  <= PROD_W'(req_a_re * req_b_re);
         s1_p_ii_ff  <= PROD_W'(req_a_im * req_b_im);
         s1_p_ir_ff  <= PROD_W'(req_a_im * req_b_re);
         s1_p_ri_ff  <= PROD_W'(req_a_re * req_b_im);
         s1_sq_r_ff  <= PROD_W'(req_b_re * req_b_re);
         s1_sq_i_ff  <= PROD_W'(req_b_im * req_b_im);
         s1_as_re_ff <= s1_as_re_in;
         s1_as_im_ff <= s1_as_im_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: numerators and divisor (one for everything but divide)
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0] s2_sum_re_in, s2_sum_im_in;
   logic [DEN_W-1:0]        s2_den_in;
   logic signed [SUM_W-1:0] s2_sum_re_ff, s2_sum_im_ff;
   logic [DEN_W-1:0]        s2_den_ff;
   cau_op_type              s2_op_ff;

   always_comb begin
      s2_den_in = DEN_W'(1);
      case (s1_op_ff) inside
         OP_ADD, OP_SUB: begin
            s2_sum_re_in = SUM_W'(s1_as_re_ff);
            s2_sum_im_in = SUM_W'(s1_as_im_ff);
         end
         OP_MUL: begin
            s2_sum_re_in = SUM_W'(s1_p_rr_ff) - SUM_W'(s1_p_ii_ff);
            s2_sum_im_in = SUM_W'(s1_p_ir_ff) + SUM_W'(s1_p_ri_ff);
         end
         default: begin
            // divide: a * conj(b) over |b|^2
            s2_sum_re_in = SUM_W'(s1_p_rr_ff) + SUM_W'(s1_p_ii_ff);
            s2_sum_im_in = SUM_W'(s1_p_ir_ff) - SUM_W'(s1_p_ri_ff);
            s2_den_in    = DEN_W'(s1_sq_r_ff) + DEN_W'(s1_sq_i_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ready[1]) begin
         s2_op_ff     <= s1_op_ff;
         s2_sum_re_ff <= s2_sum_re_in;
         s2_sum_im_ff <= s2_sum_im_in;
         s2_den_ff    <= s2_den_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: sign and magnitude, zero-divisor flag
   // ---------------------------------------------------------------------
   logic             s3_neg_re_ff, s3_neg_im_ff, s3_dz_ff;
   logic [MAG_W-1:0] s3_mag_re_ff, s3_mag_im_ff;
   logic [DEN_W-1:0] s3_den_ff;
   cau_op_type       s3_op_ff;

   function automatic logic [MAG_W-1:0] abs_sum(logic signed [SUM_W-1:0] s);
      logic [SUM_W-1:0] m;
      m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
      return m[MAG_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (ready[2]) begin
         s3_op_ff     <= s2_op_ff;
         s3_neg_re_ff <= s2_sum_re_ff[SUM_W-1];
         s3_neg_im_ff <= s2_sum_im_ff[SUM_W-1];
         s3_mag_re_ff <= abs_sum(s2_sum_re_ff);
         s3_mag_im_ff <= abs_sum(s2_sum_im_ff);
         s3_den_ff    <= s2_den_ff;
         s3_dz_ff     <= (s2_den_ff == '0);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: scale by FRAC_BITS, flag quotients of 2^RES_W or more, and
   // seed the remainder with the numerator bits above the quotient field
   // ---------------------------------------------------------------------
   cau_div_type div_word [0:NUM_DIV];
   cau_div_type s4_in;
   cau_div_type s4_ff;

   function automatic cau_part_type load_part(logic neg, logic [MAG_W-1:0] mag,
                                              cau_op_type op, logic [DEN_W-1:0] den);
      logic [MW-1:0] m;
      cau_part_type  p;
      case (op) inside
         OP_DIV:  m = MW'(mag) << FRAC_BITS;
         OP_MUL:  m = MW'(mag >> FRAC_BITS);
         default: m = MW'(mag);
      endcase
      p.rem  = REM_W'(m >> RES_W);
      p.bits = m[RES_W-1:0];
      p.neg  = neg;
      p.ovf  = (DEN_W'(m >> RES_W) >= den);
      return p;
   endfunction

   always_comb begin
      s4_in.re  = load_part(s3_neg_re_ff, s3_mag_re_ff, s3_op_ff, s3_den_ff);
      s4_in.im  = load_part(s3_neg_im_ff, s3_mag_im_ff, s3_op_ff, s3_den_ff);
      s4_in.den = s3_den_ff;
      s4_in.dz  = s3_dz_ff;
   end

   always_ff @(posedge clock) begin
      if (ready[DIV_STG0-1]) begin
         s4_ff <= s4_in;
      end
   end

   assign div_word[0] = s4_ff;

   // ---------------------------------------------------------------------
   // Divide steps, one quotient bit per stage, both parts side by side
   // ---------------------------------------------------------------------
   for (genvar k = 0; k < NUM_DIV; k++) begin : g_div
      cau_div_step u_step (
         .clock     (clock),
         .load      (ready[DIV_STG0+k]),
         .prev_word (div_word[k]),
         .next_word (div_word[k+1])
      );
   end

   // ---------------------------------------------------------------------
   // Output stage: sign, clamp, status
   // ---------------------------------------------------------------------
   cau_res_type               fin_re, fin_im;
   logic signed [RES_W-1:0]   res_re_in, res_im_in;
   cau_status_type            status_in;
   logic signed [RES_W-1:0]   res_re_ff, res_im_ff;
   cau_status_type            status_ff;

   function automatic cau_res_type finish_part(cau_part_type p);
      logic [RES_W-1:0] q;
      logic             big;
      cau_res_type      r;
      q = p.bits;
      // a negative part may reach 2^(RES_W-1) exactly, a positive one not
      big = p.ovf || (p.neg ? (q[RES_W-1] && (|q[RES_W-2:0])) : q[RES_W-1]);
      if (big) begin
         r.val = p.neg ? RES_MIN : RES_MAX;
      end else begin
         r.val = p.neg ? RES_W'(-q) : q;
      end
      r.clamp = big;
      return r;
   endfunction

   always_comb begin
      fin_re = finish_part(div_word[NUM_DIV].re);
      fin_im = finish_part(div_word[NUM_DIV].im);
      if (div_word[NUM_DIV].dz) begin
         res_re_in = '0;
         res_im_in = '0;
         status_in = ST_DIV_ZERO;
      end else begin
         res_re_in = fin_re.val;
         res_im_in = fin_im.val;
         status_in = (fin_re.clamp || fin_im.clamp) ? ST_SAT : ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (ready[OUT_STG]) begin
         res_re_ff <= res_re_in;
         res_im_ff <= res_im_in;
         status_ff <= status_in;
      end
   end

   assign rsp_res_re = res_re_ff;
   assign rsp_res_im = res_im_ff;
   assign rsp_status = status_ff;

`ifndef SYNTHESIS
   // input is refused only with every stage occupied
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("input stalled with an empty stage");

   a_div_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_DIV_ZERO) |-> (rsp_res_re == '0 && rsp_res_im == '0))
      else $error("divide by zero with nonzero result");

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_SAT) |->
         (rsp_res_re == RES_MAX || rsp_res_re == RES_MIN ||
          rsp_res_im == RES_MAX || rsp_res_im == RES_MIN))
      else $error("saturated status without a clamped part");

   // divider seed must sit below the divisor unless flagged as overflow
   a_seed_re: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DIV_STG0-1] && !div_word[0].dz && !div_word[0].re.ovf) |->
         (div_word[0].re.rem < REM_W'(div_word[0].den)))
      else $error("real remainder seed not below divisor");

   a_seed_im: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[DIV_STG0-1] && !div_word[0].dz && !div_word[0].im.ovf) |->
         (div_word[0].im.rem < REM_W'(div_word[0].den)))
      else $error("imaginary remainder seed not below divisor");
`endif

endmodule

### verif/complex_arithmetic_unit_core_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// complex_arithmetic_unit_core_tb
// Self-checking bench for the complex arithmetic unit. A short directed set
// of extreme and corner operands is followed by random words. Every accepted
// word is run through a local model of the unit, and each output word is
// compared with the oldest prediction. Input bursts and output stalls are
// random, with one long output hold that backs the pipeline up to the input.
// ============================================================================
module complex_arithmetic_unit_core_tb
   import cau_pkg::*;
();

   localparam int FRAC        = FRAC_BITS_DEF;
   localparam int RANDOM_WORDS = 500;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;      // pipeline depth is 29
   localparam int HOLD_CYCLES = 200;      // long output hold-off
   localparam int HOLD_AFTER  = 150;      // words accepted before the hold
   localparam int REPORT_MAX  = 10;

   typedef struct {
      cau_op_type              op;
      logic signed [IN_W-1:0]  a_re;
      logic signed [IN_W-1:0]  a_im;
      logic signed [IN_W-1:0]  b_re;
      logic signed [IN_W-1:0]  b_im;
   } operand_word_type;

   typedef struct {
      logic signed [RES_W-1:0] re;
      logic signed [RES_W-1:0] im;
      cau_status_type          status;
   } complex_result_type;

   typedef struct {
      operand_word_type   word;
      complex_result_type result;
   } awaited_result_type;

   // receiver stall patterns
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_ALTERNATE
   } stall_mode_type;

   // ------------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_opcode = 2'd0;
   logic signed [IN_W-1:0]  req_a_re = '0;
   logic signed [IN_W-1:0]  req_a_im = '0;
   logic signed [IN_W-1:0]  req_b_re = '0;
   logic signed [IN_W-1:0]  req_b_im = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [RES_W-1:0] rsp_res_re;
   logic signed [RES_W-1:0] rsp_res_im;
   logic [1:0]              rsp_status;

   complex_arithmetic_unit_core #(
      .FRAC_BITS (FRAC)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .req_a_re   (req_a_re),
      .req_a_im   (req_a_im),
      .req_b_re   (req_b_re),
      .req_b_im   (req_b_im),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_res_re (rsp_res_re),
      .rsp_res_im (rsp_res_im),
      .rsp_status (rsp_status)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   operand_word_type   operand_words[$];     // words not yet offered
   awaited_result_type awaited_results[$];   // predictions in output order
   int                 mismatch_count = 0;
   int                 words_accepted = 0;
   int                 cycle_count = 0;
   logic               offer_taken = 1'b0;   // word on req_* taken at last edge

   // ------------------------------------------------------------------------
   // Local model of the unit
   // ------------------------------------------------------------------------

   // clamp one part to the 24-bit result range, noting that it clamped
   function automatic longint clamp_part(longint v, inout bit clamped);
      if (v > longint'(RES_MAX)) begin
         clamped = 1'b1;
         return longint'(RES_MAX);
      end
      if (v < longint'(RES_MIN)) begin
         clamped = 1'b1;
         return longint'(RES_MIN);
      end
      return v;
   endfunction

   function automatic complex_result_type complex_result_of(operand_word_type w);
      longint             ar, ai, br, bi;
      longint             re, im, den, sum_re, sum_im;
      bit                 clamped;
      complex_result_type r;
      ar = w.a_re;
      ai = w.a_im;
      br = w.b_re;
      bi = w.b_im;
      re = 0;
      im = 0;
      clamped = 1'b0;
      r.status = ST_OK;
      case (w.op)
         OP_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         OP_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         OP_MUL: begin
            sum_re = ar * br - ai * bi;
            sum_im = ai * br + ar * bi;
            // drop fraction bits, truncating toward zero
            sum_re = (sum_re < 0) ? -((-sum_re) >> FRAC) : (sum_re >> FRAC);
            sum_im = (sum_im < 0) ? -((-sum_im) >> FRAC) : (sum_im >> FRAC);
            re = clamp_part(sum_re, clamped);
            im = clamp_part(sum_im, clamped);
            if (clamped) r.status = ST_SAT;
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               r.status = ST_DIV_ZERO;
            end else begin
               // a * conj(b), scaled up; integer divide truncates toward zero
               sum_re = (ar * br + ai * bi) * (longint'(1) << FRAC);
               sum_im = (ai * br - ar * bi) * (longint'(1) << FRAC);
               re = clamp_part(sum_re / den, clamped);
               im = clamp_part(sum_im / den, clamped);
               if (clamped) r.status = ST_SAT;
            end
         end
      endcase
      r.re = re[RES_W-1:0];
      r.im = im[RES_W-1:0];
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_word(cau_op_type op, logic signed [IN_W-1:0] ar,
                             logic signed [IN_W-1:0] ai,
                             logic signed [IN_W-1:0] br,
                             logic signed [IN_W-1:0] bi);
      operand_word_type w;
      w.op   = op;
      w.a_re = ar;
      w.a_im = ai;
      w.b_re = br;
      w.b_im = bi;
      operand_words.push_back(w);
   endtask

   // full range most of the time, sometimes small, sometimes an extreme
   function automatic logic signed [IN_W-1:0] pick_part();
      logic [IN_W-1:0] v;
      case ($urandom_range(0, 9))
         6, 7, 8: begin
            v = IN_W'($urandom_range(0, 2047));
            v = v - 16'd1024;
         end
         9: begin
            case ($urandom_range(0, 5))
               0:       v = 16'h8000;
               1:       v = 16'h8001;
               2:       v = 16'hFFFF;
               3:       v = 16'h0000;
               4:       v = 16'h0001;
               default: v = 16'h7FFF;
            endcase
         end
         default: v = IN_W'($urandom_range(0, 65535));
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------------
   // Driver: bursts of words from the queue with random gaps between them.
   // A word stays on the bus, unchanged, until it is taken.
   // ------------------------------------------------------------------------
   int burst_left = 1;
   int gap_left = 0;

   always @(negedge clock) begin : drive_words
      operand_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !offer_taken) begin
         // still stalled: hold the word
      end else if (gap_left > 0 || operand_words.size() == 0) begin
         req_valid <= 1'b0;
         if (gap_left > 0) gap_left--;
      end else begin
         w = operand_words.pop_front();
         req_opcode <= w.op;
         req_a_re   <= w.a_re;
         req_a_im   <= w.a_im;
         req_b_re   <= w.b_re;
         req_b_im   <= w.b_im;
         req_valid  <= 1'b1;
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 40);
            // a quarter of bursts run straight into the next one
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall pattern switching between modes, plus one long hold
   // once enough words went in, so the pipeline fills and refuses input.
   // ------------------------------------------------------------------------
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left = 0;
   int             hold_left = 0;
   bit             held_once = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (!held_once && words_accepted >= HOLD_AFTER) begin
         held_once = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (mode_left == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(5, 60);
         end
         mode_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Input monitor: predict the result of every word taken
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : take_words
      awaited_result_type a;
      offer_taken <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         a.word.op   = cau_op_type'(req_opcode);
         a.word.a_re = req_a_re;
         a.word.a_im = req_a_im;
         a.word.b_re = req_b_re;
         a.word.b_im = req_b_im;
         a.result    = complex_result_of(a.word);
         awaited_results.push_back(a);
         words_accepted++;
      end
   end

   // ------------------------------------------------------------------------
   // Output monitor: compare each result word with the oldest prediction
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      awaited_result_type a;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected result word: re=%0d im=%0d status=%0d",
                        rsp_res_re, rsp_res_im, rsp_status);
         end else begin
            a = awaited_results.pop_front();
            if (rsp_res_re !== a.result.re || rsp_res_im !== a.result.im ||
                rsp_status !== a.result.status) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("mismatch %s a=(%0d,%0d) b=(%0d,%0d):",
                           a.word.op.name(), a.word.a_re, a.word.a_im,
                           a.word.b_re, a.word.b_im);
                  $display("   expected re=%0d im=%0d status=%0d, got re=%0d im=%0d status=%0d",
                           a.result.re, a.result.im, a.result.status,
                           rsp_res_re, rsp_res_im, rsp_status);
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, awaited_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      // field extremes through add and subtract
      queue_word(OP_ADD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      queue_word(OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      queue_word(OP_ADD, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh0000);
      queue_word(OP_SUB, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
      queue_word(OP_SUB, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
      queue_word(OP_SUB, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      // multiply: all parts at the negative bound saturate
      queue_word(OP_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      queue_word(OP_MUL, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      queue_word(OP_MUL, 16'sh8000, 16'sh0000, 16'sh8000, 16'sh0000);
      queue_word(OP_MUL, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
      // multiply: small negative product truncates toward zero
      queue_word(OP_MUL, -16'sd1, 16'sh0000, 16'sd255, 16'sh0000);
      queue_word(OP_MUL, -16'sd3, 16'sd5, 16'sd300, -16'sd77);
      // divide by zero, with and without a zero numerator
      queue_word(OP_DIV, 16'sd100, 16'sd200, 16'sh0000, 16'sh0000);
      queue_word(OP_DIV, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
      queue_word(OP_DIV, 16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000);
      // divide: tiny divisor; one part saturates in the first two words
      queue_word(OP_DIV, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001);
      queue_word(OP_DIV, 16'sh8000, 16'sh8000, -16'sd1, -16'sd1);
      queue_word(OP_DIV, 16'sh7FFF, 16'sh0000, 16'sh0001, 16'sh0000);
      queue_word(OP_DIV, 16'sh8000, 16'sh0000, 16'sh0001, 16'sh0000);
      // divide: negative quotients truncate toward zero
      queue_word(OP_DIV, -16'sd7, 16'sh0000, 16'sd3, 16'sh0000);
      queue_word(OP_DIV, -16'sd1, 16'sh0000, 16'sd768, 16'sh0000);
      // divide: largest divisor magnitude, purely imaginary divisor, a/a
      queue_word(OP_DIV, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000);
      queue_word(OP_DIV, 16'sd1, 16'sd1, 16'sh0000, 16'sh8000);
      queue_word(OP_DIV, 16'sd256, 16'sd256, 16'sd256, 16'sd256);

      // random words; divide gets extra zero divisors
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         operand_word_type w;
         w.op   = cau_op_type'($urandom_range(0, 3));
         w.a_re = pick_part();
         w.a_im = pick_part();
         w.b_re = pick_part();
         w.b_im = pick_part();
         if (w.op == OP_DIV && $urandom_range(0, 9) == 0) begin
            w.b_re = '0;
            w.b_im = '0;
         end
         operand_words.push_back(w);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // all words taken, then all results back, then a quiet drain
      wait (operand_words.size() == 0 && !req_valid);
      wait (awaited_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
